// ----- rtl/generational_handle_allocator_defines.svh -----
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GHA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/gha_pkg.sv -----
package gha_pkg;

	localparam int NUM_CHANNELS = 3;
	localparam int CHANNEL_SHIFT = 30;
	localparam int SLOTS_DEFAULT = 64;
	localparam logic [31:0] GEN_MAX = 32'hFFFF_FFFF;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_REGISTERED = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] channel;
		logic [31:0] handle_word;
		logic [31:0] handle_generation;
		logic callback_bound;
		logic owner_registered;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] out_handle_word;
		logic [31:0] out_generation;
	} out_item_t;

	typedef struct packed {
		logic clear_all;
		logic slot_we;
		logic slot_occ;
		logic pop;
		logic grow;
		logic push;
	} ctl_t;

	function automatic int unsigned chan_base(input logic [1:0] ch, input int unsigned slots);
		return 32'(ch) * slots;
	endfunction

endpackage

// ----- rtl/gha_ram.sv -----
module gha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/gha_exec.sv -----
module gha_exec #(
	parameter int SLOTS = gha_pkg::SLOTS_DEFAULT
) (
	input  gha_pkg::in_item_t              item,
	input  logic [$clog2(SLOTS+1)-1:0]     fc,
	input  logic [$clog2(SLOTS+1)-1:0]     uc,
	input  logic                           slot_occ,
	input  logic [31:0]                    slot_gen,
	input  logic [$clog2(SLOTS)-1:0]       stk_idx,
	input  logic [31:0]                    stk_gen,
	output gha_pkg::ctl_t                  ctl,
	output logic [$clog2(SLOTS)-1:0]       wr_idx,
	output logic [31:0]                    wr_gen,
	output gha_pkg::out_item_t             result
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	logic ch_ok;
	logic [gha_pkg::CHANNEL_SHIFT-1:0] rel_idx;
	logic [gha_pkg::CHANNEL_SHIFT-1:0] uc_ext;
	logic [gha_pkg::CHANNEL_SHIFT-1:0] idx_ext;

	assign ch_ok = item.channel < 2'(gha_pkg::NUM_CHANNELS);
	assign rel_idx = item.handle_word[gha_pkg::CHANNEL_SHIFT-1:0];

	always_comb begin
		uc_ext = '0;
		uc_ext[CNT_W-1:0] = uc;
		idx_ext = '0;
		ctl = '0;
		wr_idx = '0;
		wr_gen = '0;
		result = '0;
		case (item.op)
			gha_pkg::OP_CLEAR: begin
				ctl.clear_all = 1'b1;
				result.status = gha_pkg::ST_OK;
			end
			gha_pkg::OP_ALLOC: begin
				if (!item.owner_registered) begin
					result.status = gha_pkg::ST_NOT_REGISTERED;
				end else if (!ch_ok || !item.callback_bound) begin
					result.status = gha_pkg::ST_INVALID;
				end else if (fc != '0) begin
					ctl.pop = 1'b1;
					wr_idx = stk_idx;
					wr_gen = stk_gen;
				end else if (uc < CNT_W'(SLOTS)) begin
					ctl.grow = 1'b1;
					wr_idx = uc[IDX_W-1:0];
				end else begin
					result.status = gha_pkg::ST_FULL;
				end
				if (ctl.pop || ctl.grow) begin
					ctl.slot_we = 1'b1;
					ctl.slot_occ = 1'b1;
					idx_ext[IDX_W-1:0] = wr_idx;
					result.status = gha_pkg::ST_OK;
					result.out_handle_word = {item.channel, idx_ext};
					result.out_generation = wr_gen;
				end
			end
			gha_pkg::OP_RELEASE: begin
				if (!item.owner_registered || !ch_ok
						|| item.handle_word[31:gha_pkg::CHANNEL_SHIFT] != item.channel
						|| rel_idx >= uc_ext || !slot_occ
						|| slot_gen != item.handle_generation) begin
					result.status = gha_pkg::ST_NOT_REGISTERED;
				end else begin
					result.status = gha_pkg::ST_OK;
					ctl.slot_we = 1'b1;
					wr_idx = rel_idx[IDX_W-1:0];
					if (slot_gen == gha_pkg::GEN_MAX) begin
						wr_gen = slot_gen;
					end else begin
						wr_gen = slot_gen + 32'd1;
						ctl.push = fc < CNT_W'(SLOTS);
					end
				end
			end
			default: begin
				result.status = gha_pkg::ST_INVALID;
			end
		endcase
	end

endmodule

// ----- rtl/generational_handle_allocator.sv -----
// Generational handle allocator with three slot tables of SLOTS entries each. In the cycle
// an item is accepted, the slot table RAM (generation and occupancy) and the free stack RAM
// are read; once the output register can take a result, the item is checked, the RAMs are
// written where the item changes them and the result is loaded into the output register.
// req_stall is high from acceptance until then, so a new item is not taken while one is
// being worked on; one finished result can wait in the output register while the next
// item is taken. Clear only resets the per-table counters, since entries beyond a
// table's used count are treated as fresh, so there is no clearing pass after reset.
module generational_handle_allocator #(
	parameter int SLOTS = gha_pkg::SLOTS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  gha_pkg::in_item_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output gha_pkg::out_item_t rsp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int DEPTH = gha_pkg::NUM_CHANNELS * SLOTS;
	localparam int AW = $clog2(DEPTH);
	localparam int SLOT_W = 33;
	localparam int STK_W = IDX_W + 32;

	logic v_s1;
	gha_pkg::in_item_t item_s1;
	logic [CNT_W-1:0] fc_q [gha_pkg::NUM_CHANNELS];
	logic [CNT_W-1:0] uc_q [gha_pkg::NUM_CHANNELS];

	logic accept;
	logic go;
	logic [1:0] ch_in;
	logic [1:0] ch_s1;
	logic [AW-1:0] base_in;
	logic [AW-1:0] base_s1;
	logic [AW-1:0] slot_raddr;
	logic [AW-1:0] slot_waddr;
	logic [AW-1:0] stk_raddr;
	logic [AW-1:0] stk_waddr;
	logic [SLOT_W-1:0] slot_rd;
	logic [STK_W-1:0] stk_rd;
	gha_pkg::ctl_t ctl;
	logic [IDX_W-1:0] wr_idx;
	logic [31:0] wr_gen;
	gha_pkg::out_item_t result;

	assign req_stall = v_s1;
	assign accept = req_valid && !v_s1;
	assign go = v_s1 && (!rsp_valid || !rsp_stall);

	assign ch_in = (req.channel < 2'(gha_pkg::NUM_CHANNELS)) ? req.channel : '0;
	assign ch_s1 = (item_s1.channel < 2'(gha_pkg::NUM_CHANNELS)) ? item_s1.channel : '0;
	assign base_in = AW'(gha_pkg::chan_base(ch_in, SLOTS));
	assign base_s1 = AW'(gha_pkg::chan_base(ch_s1, SLOTS));

	assign slot_raddr = base_in + AW'(req.handle_word[IDX_W-1:0]);
	assign stk_raddr = base_in + AW'(fc_q[ch_in]) - AW'(1);
	assign slot_waddr = base_s1 + AW'(wr_idx);
	assign stk_waddr = base_s1 + AW'(fc_q[ch_s1]);

	gha_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(DEPTH)
	) u_slot_ram (
		.clk(clk),
		.we(go && ctl.slot_we),
		.waddr(slot_waddr),
		.wdata({ctl.slot_occ, wr_gen}),
		.re(accept),
		.raddr(slot_raddr),
		.rdata(slot_rd)
	);

	gha_ram #(
		.WIDTH(STK_W),
		.DEPTH(DEPTH)
	) u_stack_ram (
		.clk(clk),
		.we(go && ctl.push),
		.waddr(stk_waddr),
		.wdata({wr_idx, wr_gen}),
		.re(accept),
		.raddr(stk_raddr),
		.rdata(stk_rd)
	);

	gha_exec #(
		.SLOTS(SLOTS)
	) u_exec (
		.item(item_s1),
		.fc(fc_q[ch_s1]),
		.uc(uc_q[ch_s1]),
		.slot_occ(slot_rd[SLOT_W-1]),
		.slot_gen(slot_rd[31:0]),
		.stk_idx(stk_rd[STK_W-1:32]),
		.stk_gen(stk_rd[31:0]),
		.ctl(ctl),
		.wr_idx(wr_idx),
		.wr_gen(wr_gen),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (go) begin
				v_s1 <= 1'b0;
			end
			if (go) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
		if (go) begin
			rsp <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gha_pkg::NUM_CHANNELS; i++) begin
				fc_q[i] <= '0;
				uc_q[i] <= '0;
			end
		end else if (go) begin
			if (ctl.clear_all) begin
				for (int i = 0; i < gha_pkg::NUM_CHANNELS; i++) begin
					fc_q[i] <= '0;
					uc_q[i] <= '0;
				end
			end else begin
				if (ctl.pop) begin
					fc_q[ch_s1] <= fc_q[ch_s1] - CNT_W'(1);
				end
				if (ctl.push) begin
					fc_q[ch_s1] <= fc_q[ch_s1] + CNT_W'(1);
				end
				if (ctl.grow) begin
					uc_q[ch_s1] <= uc_q[ch_s1] + CNT_W'(1);
				end
			end
		end
	end

endmodule

// ----- rtl/gha_checker.sv -----
`include "generational_handle_allocator_defines.svh"

module gha_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input gha_pkg::in_item_t  req,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input gha_pkg::out_item_t rsp
);

	logic req_waiting;
	logic req_taken;
	logic rsp_waiting;
	logic rsp_failed;
	logic rsp_zero;

	assign req_waiting = req_valid && req_stall;
	assign req_taken = req_valid && !req_stall;
	assign rsp_waiting = rsp_valid && rsp_stall;
	assign rsp_failed = rsp_valid && (rsp.status != gha_pkg::ST_OK);
	assign rsp_zero = (rsp.out_handle_word == 32'd0) && (rsp.out_generation == 32'd0);

	// A stalled result must hold.
	`GHA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_waiting, rsp_valid && $stable(rsp), "result changed")

	// A stalled item must hold.
	`GHA_ASSERT_NEXT(a_req_hold, clk, arst_n, req_waiting, req_valid && $stable(req), "item changed")

	// An accepted item occupies the block for the following cycle.
	`GHA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_taken, req_stall, "no stall after item")

	// A new result only appears after an item was being worked on.
	`GHA_ASSERT_NOW(a_rsp_from_item, clk, arst_n, $rose(rsp_valid), $past(req_stall), "stray result")

	// Failed operations return a zero handle and generation.
	`GHA_ASSERT_NOW(a_fail_zero, clk, arst_n, rsp_failed, rsp_zero, "nonzero handle on failure")

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (.*);

// ----- tb/generational_handle_allocator_test.sv -----
`timescale 1ns / 1ps

module generational_handle_allocator_test;

	localparam int SLOTS = gha_pkg::SLOTS_DEFAULT;
	localparam int NCH = gha_pkg::NUM_CHANNELS;
	localparam int CSH = gha_pkg::CHANNEL_SHIFT;
	localparam int HOLD_CYCLES = 150;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 20;
	localparam int REPORT_LIMIT = 10;
	localparam logic [1:0] NO_CHANNEL = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	gha_pkg::in_item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	gha_pkg::out_item_t rsp;

	logic [31:0] gen_table [NCH][SLOTS];
	bit occupied [NCH][SLOTS];
	bit retired [NCH][SLOTS];
	int unsigned free_list [NCH][SLOTS];
	int unsigned free_depth [NCH];
	int unsigned grown [NCH];

	gha_pkg::out_item_t pending_responses [$];
	int unsigned mismatches = 0;
	bit idle_on = 1'b1;
	int unsigned hold_requests = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	generational_handle_allocator #(.SLOTS(SLOTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	function automatic void clear_tables();
		for (int c = 0; c < NCH; c++) begin
			for (int s = 0; s < SLOTS; s++) begin
				gen_table[c][s] = '0;
				occupied[c][s] = 1'b0;
				retired[c][s] = 1'b0;
				free_list[c][s] = 0;
			end
			free_depth[c] = 0;
			grown[c] = 0;
		end
	endfunction

	function automatic gha_pkg::out_item_t compute_response(input gha_pkg::in_item_t it);
		gha_pkg::out_item_t r;
		int unsigned ch;
		int unsigned idx;
		bit granted;
		r = '0;
		ch = 32'(it.channel);
		idx = 0;
		granted = 1'b0;
		if (it.op == gha_pkg::OP_CLEAR) begin
			clear_tables();
			r.status = gha_pkg::ST_OK;
		end else if (it.op == gha_pkg::OP_RSVD) begin
			r.status = gha_pkg::ST_INVALID;
		end else if (!it.owner_registered) begin
			r.status = gha_pkg::ST_NOT_REGISTERED;
		end else if (it.op == gha_pkg::OP_ALLOC) begin
			if (ch >= NCH || !it.callback_bound) begin
				r.status = gha_pkg::ST_INVALID;
			end else if (free_depth[ch] > 0) begin
				free_depth[ch]--;
				idx = free_list[ch][free_depth[ch]];
				granted = 1'b1;
			end else if (grown[ch] < SLOTS) begin
				idx = grown[ch];
				grown[ch]++;
				granted = 1'b1;
			end else begin
				r.status = gha_pkg::ST_FULL;
			end
			if (granted) begin
				occupied[ch][idx] = 1'b1;
				r.status = gha_pkg::ST_OK;
				r.out_handle_word = {2'(ch), 30'(idx)};
				r.out_generation = gen_table[ch][idx];
			end
		end else begin
			idx = 32'(it.handle_word[CSH-1:0]);
			if (ch >= NCH || 32'(it.handle_word[31:CSH]) != ch) begin
				r.status = gha_pkg::ST_NOT_REGISTERED;
			end else if (idx >= grown[ch] || idx >= SLOTS) begin
				r.status = gha_pkg::ST_NOT_REGISTERED;
			end else if (!occupied[ch][idx]
					|| gen_table[ch][idx] != it.handle_generation) begin
				r.status = gha_pkg::ST_NOT_REGISTERED;
			end else begin
				occupied[ch][idx] = 1'b0;
				if (gen_table[ch][idx] == gha_pkg::GEN_MAX) begin
					retired[ch][idx] = 1'b1;
				end else begin
					gen_table[ch][idx] = gen_table[ch][idx] + 32'd1;
					if (free_depth[ch] < SLOTS) begin
						free_list[ch][free_depth[ch]] = idx;
						free_depth[ch]++;
					end
				end
				r.status = gha_pkg::ST_OK;
			end
		end
		return r;
	endfunction

	function automatic int pick_live(input int unsigned ch);
		int unsigned live [$];
		for (int unsigned s = 0; s < grown[ch]; s++) begin
			if (occupied[ch][s]) live = {live, s};
		end
		if (live.size() == 0) return -1;
		return int'(live[$urandom_range(live.size() - 1)]);
	endfunction

	function automatic gha_pkg::in_item_t base_item(input logic [1:0] op,
			input int unsigned ch);
		gha_pkg::in_item_t it;
		it.op = op;
		it.channel = 2'(ch);
		it.handle_word = $urandom;
		it.handle_generation = $urandom;
		it.callback_bound = 1'b1;
		it.owner_registered = 1'b1;
		return it;
	endfunction

	function automatic gha_pkg::in_item_t release_of(input int unsigned ch,
			input int unsigned idx, input logic [31:0] g);
		gha_pkg::in_item_t it;
		it = base_item(gha_pkg::OP_RELEASE, ch);
		it.handle_word = {2'(ch), 30'(idx)};
		it.handle_generation = g;
		return it;
	endfunction

	function automatic gha_pkg::in_item_t noise_item();
		gha_pkg::in_item_t it;
		it.op = 2'($urandom);
		it.channel = 2'($urandom);
		it.handle_word = $urandom;
		it.handle_generation = $urandom;
		it.callback_bound = 1'($urandom);
		it.owner_registered = 1'($urandom);
		return it;
	endfunction

	function automatic gha_pkg::in_item_t broken_item(input int unsigned ch);
		gha_pkg::in_item_t it;
		int live;
		live = pick_live(ch);
		if (live >= 0) it = release_of(ch, live, gen_table[ch][live]);
		else it = release_of(ch, 0, $urandom);
		case ($urandom_range(5))
			0: it.handle_generation = it.handle_generation ^ (32'($urandom) | 32'd1);
			1: it.handle_word[31:CSH] = 2'((ch + 1 + $urandom_range(2)) % 4);
			2: begin
				it.owner_registered = 1'b0;
				if ($urandom_range(1) == 1) it.op = gha_pkg::OP_ALLOC;
			end
			3: begin
				it.op = gha_pkg::OP_ALLOC;
				it.callback_bound = 1'b0;
			end
			4: begin
				it.channel = NO_CHANNEL;
				it.handle_word[31:CSH] = NO_CHANNEL;
				if ($urandom_range(1) == 1) it.op = gha_pkg::OP_ALLOC;
			end
			default: it.handle_word[CSH-1:0] = 30'(grown[ch] + $urandom_range(SLOTS));
		endcase
		return it;
	endfunction

	function automatic gha_pkg::in_item_t pick_item(input int unsigned alloc_pct,
			input int unsigned focus);
		gha_pkg::in_item_t it;
		int unsigned ch;
		int unsigned r;
		int live;
		ch = ($urandom_range(99) < 60) ? focus : $urandom_range(NCH - 1);
		r = $urandom_range(99);
		live = pick_live(ch);
		if (r < 2) begin
			it = noise_item();
			if (it.op == gha_pkg::OP_CLEAR) it.op = gha_pkg::OP_RSVD;
		end else if (r < 8) begin
			it = broken_item(ch);
		end else if (live < 0 || $urandom_range(99) < alloc_pct) begin
			it = base_item(gha_pkg::OP_ALLOC, ch);
		end else begin
			it = release_of(ch, live, gen_table[ch][live]);
		end
		return it;
	endfunction

	task automatic send_item(input gha_pkg::in_item_t it);
		gha_pkg::out_item_t want;
		while (idle_on && $urandom_range(99) < 8) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		want = compute_response(it);
		pending_responses = {pending_responses, want};
	endtask

	function automatic void note_mismatch(input string what, input gha_pkg::out_item_t want,
			input gha_pkg::out_item_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s: expected status %0d handle %h generation %h,",
				$realtime, what, want.status, want.out_handle_word, want.out_generation,
				" got status %0d handle %h generation %h",
				got.status, got.out_handle_word, got.out_generation);
	endfunction

	always @(posedge clk) begin
		gha_pkg::out_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_responses.size() == 0) begin
				note_mismatch("result with no item waiting", '0, rsp);
			end else begin
				want = pending_responses.pop_front();
				if (rsp.status !== want.status
						|| rsp.out_handle_word !== want.out_handle_word
						|| rsp.out_generation !== want.out_generation)
					note_mismatch("result mismatch", want, rsp);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= idle_on && ($urandom_range(99) < 8);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic test_directed();
		gha_pkg::in_item_t it;
		send_item(base_item(gha_pkg::OP_ALLOC, 0));
		send_item(base_item(gha_pkg::OP_ALLOC, 1));
		send_item(base_item(gha_pkg::OP_ALLOC, 2));
		send_item(base_item(gha_pkg::OP_ALLOC, 1));
		send_item(base_item(gha_pkg::OP_ALLOC, NO_CHANNEL));
		it = base_item(gha_pkg::OP_ALLOC, 0);
		it.callback_bound = 1'b0;
		send_item(it);
		it = base_item(gha_pkg::OP_ALLOC, 0);
		it.owner_registered = 1'b0;
		send_item(it);
		// Two releases then an allocate: the most recently freed slot comes back first.
		send_item(release_of(1, 0, 0));
		send_item(release_of(1, 1, 0));
		send_item(base_item(gha_pkg::OP_ALLOC, 1));
		send_item(release_of(1, 0, 0));
		send_item(release_of(0, 0, 32'd1));
		it = release_of(0, 0, 0);
		it.handle_word[31:CSH] = 2'd2;
		send_item(it);
		it = release_of(0, 0, 0);
		it.handle_word[CSH-1:0] = '1;
		send_item(it);
		send_item(release_of(NO_CHANNEL, 0, 0));
		it = release_of(0, 0, 0);
		it.owner_registered = 1'b0;
		send_item(it);
		send_item(release_of(0, 0, 0));
		it = '1;
		send_item(it);
		it = '1;
		it.op = gha_pkg::OP_CLEAR;
		it.owner_registered = 1'b0;
		send_item(it);
		it = base_item(gha_pkg::OP_ALLOC, 2);
		it.handle_word = '1;
		it.handle_generation = '1;
		send_item(it);
		it = '0;
		send_item(it);
		it = base_item(gha_pkg::OP_ALLOC, 0);
		it.handle_word = '0;
		it.handle_generation = '0;
		send_item(it);
	endtask

	task automatic test_fill_and_drain();
		gha_pkg::in_item_t it;
		int unsigned focus;
		for (int round = 0; round < 2; round++) begin
			focus = $urandom_range(NCH - 1);
			repeat (220) send_item(pick_item(90, focus));
			repeat (130) send_item(pick_item(15, focus));
			it = noise_item();
			it.op = gha_pkg::OP_CLEAR;
			send_item(it);
		end
	endtask

	task automatic test_noise();
		repeat (150) send_item(noise_item());
	endtask

	task automatic test_backpressure();
		hold_requests <= hold_requests + 1;
		repeat (100) send_item(pick_item(50, $urandom_range(NCH - 1)));
	endtask

	task automatic test_steady_stream();
		idle_on = 1'b0;
		repeat (150) send_item(pick_item(50, $urandom_range(NCH - 1)));
		idle_on = 1'b1;
	endtask

	initial begin
		clear_tables();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_and_drain();
		test_noise();
		test_backpressure();
		test_steady_stream();
		req_valid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_responses.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/gha_pkg.sv
rtl/gha_ram.sv
rtl/gha_exec.sv
rtl/generational_handle_allocator.sv
rtl/gha_checker.sv
tb/generational_handle_allocator_test.sv
